FILE: rtl/gpio_eec_pkg.sv
// Shared types and constants for the GPIO edge event channel unit.
// No dependencies; used by gpio_eec_ctrl, gpio_eec_dp and the top level.
package gpio_eec_pkg;

   // Command codes carried in the request
   localparam logic [2:0] CMD_REGISTER = 3'd0;
   localparam logic [2:0] CMD_ENABLE   = 3'd1;
   localparam logic [2:0] CMD_DISABLE  = 3'd2;
   localparam logic [2:0] CMD_TICK     = 3'd3;
   localparam logic [2:0] CMD_SERVICE  = 3'd4;

   // Edge polarity codes
   localparam logic [1:0] POL_FALL    = 2'd0;
   localparam logic [1:0] POL_RISE    = 2'd1;
   localparam logic [1:0] POL_ANY     = 2'd2;
   localparam logic [1:0] POL_INVALID = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NO_INIT = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_POL     = 3'd3;
   localparam logic [2:0] ST_PIN     = 3'd4;

   // Reported events per service request
   localparam int MAX_RESULTS = 8;
   localparam int RES_W       = $clog2(MAX_RESULTS);

   // Field widths
   localparam int CMD_W = 3;
   localparam int PIN_W = 5;
   localparam int POL_W = 2;
   localparam int LVL_W = 32;
   localparam int ST_W  = 3;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // single-result command, load result register
      logic scan_step; // service one channel at the scan index
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scan; // service request with at least one handled event
      logic out_free;  // result register can take a new result
      logic step_emit; // channel at scan index reports an event
      logic step_last; // that report is the final one
   } dp_sts_type;

endpackage

FILE: rtl/gpio_eec_ctrl.sv
// Sequencer for the GPIO edge event channel unit.
// Depends on gpio_eec_pkg (command and status structs).
module gpio_eec_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  gpio_eec_pkg::dp_sts_type  sts,
   output gpio_eec_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.execute   = 1'b0;
      cmd.scan_step = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.need_scan) begin
               state_in = S_SCAN;
            end else if (sts.out_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            // channels without a report advance freely; a report waits for room
            if (!sts.step_emit || sts.out_free) begin
               cmd.scan_step = 1'b1;
               if (sts.step_emit && sts.step_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/gpio_eec_dp.sv
// Datapath of the GPIO edge event channel unit: channel tables, flags,
// pin level history and the result register. Depends on gpio_eec_pkg.
module gpio_eec_dp #(
   parameter int CHANNELS = 8,
   parameter int PINS     = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_data,
   input  logic [gpio_eec_pkg::CMD_W-1:0]      req_command,
   input  logic [gpio_eec_pkg::PIN_W-1:0]      req_pin,
   input  logic [gpio_eec_pkg::POL_W-1:0]      req_polarity,
   input  logic                                req_has_handler,
   input  logic [gpio_eec_pkg::LVL_W-1:0]      req_pin_levels,
   input  gpio_eec_pkg::ctl_cmd_type           cmd,
   output gpio_eec_pkg::dp_sts_type            sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gpio_eec_pkg::ST_W-1:0]       rsp_status,
   output logic                                rsp_event_valid,
   output logic [gpio_eec_pkg::PIN_W-1:0]      rsp_event_pin,
   output logic                                rsp_event_level,
   output logic                                rsp_last
);

   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LVL_W = gpio_eec_pkg::LVL_W;
   localparam int PIN_W = gpio_eec_pkg::PIN_W;
   localparam int POL_W = gpio_eec_pkg::POL_W;
   localparam int RES_W = gpio_eec_pkg::RES_W;
   localparam int MAX_RESULTS_M1 = gpio_eec_pkg::MAX_RESULTS - 1;
   // pins at or above PINS always read low
   localparam logic [LVL_W-1:0] LV_MASK =
      (PINS >= LVL_W) ? {LVL_W{1'b1}} : LVL_W'((64'd1 << PINS) - 64'd1);

   // Unit state
   logic                  ready_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PIN_W-1:0]      pin_tbl_ff [CHANNELS];
   logic [POL_W-1:0]      pol_tbl_ff [CHANNELS];
   logic                  tbl_we;
   logic [CHANNELS-1:0]   handler_ff, handler_in;
   logic [CHANNELS-1:0]   enable_ff, enable_in;
   logic [CHANNELS-1:0]   latch_ff, latch_in;
   logic [LVL_W-1:0]      prev_lv_ff, prev_lv_in;

   // Captured request
   logic [gpio_eec_pkg::CMD_W-1:0] cmd_ff;
   logic [PIN_W-1:0]      pin_ff;
   logic [POL_W-1:0]      pol_ff;
   logic                  hnd_ff;
   logic [LVL_W-1:0]      lv_ff;

   // Service scan position and report count
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [RES_W-1:0]      nres_ff, nres_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [gpio_eec_pkg::ST_W-1:0] rsp_status_ff, rsp_status_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [PIN_W-1:0]      rsp_pin_ff, rsp_pin_in;
   logic                  rsp_lvl_ff, rsp_lvl_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Derived vectors
   logic [CHANNELS-1:0]   below_cnt;
   logic [CHANNELS-1:0]   above_idx;
   logic [CHANNELS-1:0]   match;
   logic [CHANNELS-1:0]   hit;
   logic [CHANNELS-1:0]   pend;
   logic [IDX_W-1:0]      found_idx;
   logic                  found;
   logic                  more;
   logic [LVL_W-1:0]      lvm;
   logic [LVL_W-1:0]      rise;
   logic [LVL_W-1:0]      fall;
   logic [gpio_eec_pkg::ST_W-1:0] exec_st;
   logic                  reg_ok;

   assign lvm  = lv_ff & LV_MASK;
   assign rise = lvm & ~prev_lv_ff;
   assign fall = prev_lv_ff & ~lvm;

   // Per-channel compares: occupancy, scan position, pin match, edge hit
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         below_cnt[i] = (CNT_W'(i) < count_ff);
         above_idx[i] = (IDX_W'(i) > idx_ff);
         match[i]     = below_cnt[i] && (pin_tbl_ff[i] == pin_ff);
         case (pol_tbl_ff[i])
            gpio_eec_pkg::POL_FALL: hit[i] = fall[pin_tbl_ff[i]];
            gpio_eec_pkg::POL_RISE: hit[i] = rise[pin_tbl_ff[i]];
            default:                hit[i] = rise[pin_tbl_ff[i]] | fall[pin_tbl_ff[i]];
         endcase
         hit[i] = hit[i] && enable_ff[i] && below_cnt[i];
      end
   end

   // Lowest channel holding the requested pin
   always_comb begin
      found_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (match[i]) begin
            found_idx = IDX_W'(i);
         end
      end
   end
   assign found = |match;

   assign pend = latch_ff & handler_ff & below_cnt;
   assign more = |(pend & above_idx);

   assign sts.need_scan = (cmd_ff == gpio_eec_pkg::CMD_SERVICE) && ready_ff && (|pend);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.step_emit = pend[idx_ff];
   assign sts.step_last = !more || (nres_ff == RES_W'(MAX_RESULTS_M1));

   assign reg_ok = (count_ff < CNT_W'(CHANNELS)) && (pol_ff != gpio_eec_pkg::POL_INVALID);

   // Status of a single-result command
   always_comb begin
      exec_st = gpio_eec_pkg::ST_OK;
      case (cmd_ff)
         gpio_eec_pkg::CMD_TICK: begin
            if (!ready_ff) exec_st = gpio_eec_pkg::ST_NO_INIT;
         end
         gpio_eec_pkg::CMD_REGISTER: begin
            if (!ready_ff) begin
               exec_st = gpio_eec_pkg::ST_NO_INIT;
            end else if (count_ff >= CNT_W'(CHANNELS)) begin
               exec_st = gpio_eec_pkg::ST_FULL;
            end else if (pol_ff == gpio_eec_pkg::POL_INVALID) begin
               exec_st = gpio_eec_pkg::ST_POL;
            end
         end
         gpio_eec_pkg::CMD_ENABLE, gpio_eec_pkg::CMD_DISABLE: begin
            if (!ready_ff) begin
               exec_st = gpio_eec_pkg::ST_NO_INIT;
            end else if (!found) begin
               exec_st = gpio_eec_pkg::ST_PIN;
            end
         end
         gpio_eec_pkg::CMD_SERVICE: begin
            if (!ready_ff) exec_st = gpio_eec_pkg::ST_NO_INIT;
         end
         default: begin
            exec_st = gpio_eec_pkg::ST_OK;
         end
      endcase
   end

   // Next-state logic
   always_comb begin
      count_in      = count_ff;
      handler_in    = handler_ff;
      enable_in     = enable_ff;
      latch_in      = latch_ff;
      prev_lv_in    = prev_lv_ff;
      idx_in        = idx_ff;
      nres_in       = nres_ff;
      tbl_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_pin_in    = rsp_pin_ff;
      rsp_lvl_in    = rsp_lvl_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.capture) begin
         idx_in  = '0;
         nres_in = '0;
      end

      if (cmd.execute) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = exec_st;
         rsp_ev_in     = 1'b0;
         rsp_pin_in    = '0;
         rsp_lvl_in    = 1'b0;
         rsp_last_in   = 1'b1;
         case (cmd_ff)
            gpio_eec_pkg::CMD_TICK: begin
               if (ready_ff) latch_in = latch_ff | hit;
               prev_lv_in = lvm;
            end
            gpio_eec_pkg::CMD_REGISTER: begin
               if (ready_ff && reg_ok) begin
                  tbl_we = 1'b1;
                  handler_in[count_ff[IDX_W-1:0]] = hnd_ff;
                  latch_in[count_ff[IDX_W-1:0]]   = 1'b0;
                  enable_in[count_ff[IDX_W-1:0]]  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            gpio_eec_pkg::CMD_ENABLE: begin
               if (ready_ff && found) begin
                  latch_in[found_idx]  = 1'b0;
                  enable_in[found_idx] = 1'b1;
               end
            end
            gpio_eec_pkg::CMD_DISABLE: begin
               if (ready_ff && found) enable_in[found_idx] = 1'b0;
            end
            gpio_eec_pkg::CMD_SERVICE: begin
               // nothing to report: every latched event is dropped
               if (ready_ff) latch_in = latch_ff & ~below_cnt;
            end
            default: begin
               latch_in = latch_ff;
            end
         endcase
      end

      // One channel of a service scan
      if (cmd.scan_step) begin
         latch_in[idx_ff] = 1'b0;
         idx_in = idx_ff + IDX_W'(1);
         if (sts.step_emit) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = gpio_eec_pkg::ST_OK;
            rsp_ev_in     = 1'b1;
            rsp_pin_in    = pin_tbl_ff[idx_ff];
            rsp_lvl_in    = prev_lv_ff[pin_tbl_ff[idx_ff]];
            rsp_last_in   = sts.step_last;
            nres_in       = nres_ff + RES_W'(1);
            // last report below the cap: latched events of the channels above are dropped
            if (!more && (nres_ff != RES_W'(MAX_RESULTS_M1))) begin
               latch_in = latch_in & ~(above_idx & below_cnt);
            end
         end
      end
   end

   // Control and flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         count_ff     <= '0;
         handler_ff   <= '0;
         enable_ff    <= '0;
         latch_ff     <= '0;
         prev_lv_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) ready_ff <= csr_data;
         count_ff     <= count_in;
         handler_ff   <= handler_in;
         enable_ff    <= enable_in;
         latch_ff     <= latch_in;
         prev_lv_ff   <= prev_lv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_command;
         pin_ff <= req_pin;
         pol_ff <= req_polarity;
         hnd_ff <= req_has_handler;
         lv_ff  <= req_pin_levels;
      end
      if (tbl_we) begin
         pin_tbl_ff[count_ff[IDX_W-1:0]] <= pin_ff;
         pol_tbl_ff[count_ff[IDX_W-1:0]] <= pol_ff;
      end
      idx_ff        <= idx_in;
      nres_ff       <= nres_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_pin_ff    <= rsp_pin_in;
      rsp_lvl_ff    <= rsp_lvl_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_event_valid = rsp_ev_ff;
   assign rsp_event_pin   = rsp_pin_ff;
   assign rsp_event_level = rsp_lvl_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: rtl/gpio_edge_event_channels_unit.sv
// Top level of the GPIO edge event channel unit.
// Depends on gpio_eec_pkg, gpio_eec_ctrl and gpio_eec_dp.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_tvalid/req_tready  | req_tdata (command, pin, ...)
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata, rsp_tlast
//  csr     | in        | csr_valid/csr_ready    | csr_data (unit_ready)
//
// Register, enable, disable, tick and unknown commands: the request is accepted,
// then state is updated and the result register loaded once it is free. Service
// without a pending handled event does the same; otherwise the walk visits the
// channels up to the last report, one per cycle while no report waits for room.
// Reset is synchronous, active high; the channel tables are not cleared.
// A full result register holds the sequencer until rsp_tready frees it.
module gpio_edge_event_channels_unit #(
   parameter int CHANNELS = 8,
   parameter int PINS     = 32
) (
   input  logic        clock,
   input  logic        reset,
   // command[2:0], pin[7:3], polarity[9:8], has_handler[10],
   // pin_levels[42:11], zero pad [47:43]
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // status[2:0], event_valid[3], event_pin[8:4], event_level[9], zero pad [15:10]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   gpio_eec_pkg::ctl_cmd_type ctl_cmd;
   gpio_eec_pkg::dp_sts_type  dp_sts;
   logic [2:0] rsp_status;
   logic       rsp_event_valid;
   logic [4:0] rsp_event_pin;
   logic       rsp_event_level;

   assign csr_ready = 1'b1;

   gpio_eec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   gpio_eec_dp #(
      .CHANNELS (CHANNELS),
      .PINS     (PINS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .req_command     (req_tdata[2:0]),
      .req_pin         (req_tdata[7:3]),
      .req_polarity    (req_tdata[9:8]),
      .req_has_handler (req_tdata[10]),
      .req_pin_levels  (req_tdata[42:11]),
      .cmd             (ctl_cmd),
      .sts             (dp_sts),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_event_valid (rsp_event_valid),
      .rsp_event_pin   (rsp_event_pin),
      .rsp_event_level (rsp_event_level),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, rsp_event_level, rsp_event_pin, rsp_event_valid, rsp_status};

   // A result is never loaded over one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.execute || (ctl_cmd.scan_step && dp_sts.step_emit)) |-> dp_sts.out_free)
      else $error("result register overwritten");

   // One request at a time: no accept in the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // A result without an event is always the only one of its request
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_event_valid) |-> rsp_tlast)
      else $error("non-event result not marked last");

   // Scan and single-result execution never coincide, and capture needs a valid request
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ctl_cmd.execute && ctl_cmd.scan_step) && !(ctl_cmd.capture && !req_tvalid))
      else $error("conflicting datapath commands");

endmodule
